### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the slot table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle implication check failed");

`endif

### rtl/core/tstr_pkg.sv
// Shared constants, codes and command types of the tagged slot table.
package tstr_pkg;

   // Table geometry.
   localparam int SLOTS      = 16;
   localparam int DATA_BITS  = 32;
   localparam int SLOT_IDX_W = $clog2(SLOTS);

   // Fixed field widths.
   localparam int ITEM_BITS    = 16;
   localparam int OWNER_BITS   = 8;
   localparam int COUNT_BITS   = 8;
   localparam int PAYLOAD_BITS = 32;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_STORE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_STORED = 2'd0,
      ST_FULL   = 2'd1,
      ST_HIT    = 2'd2,
      ST_MISS   = 2'd3
   } status_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      op_type                  op;
      logic [ITEM_BITS-1:0]    item_id;
      logic [OWNER_BITS-1:0]   owner_id;
      logic [COUNT_BITS-1:0]   count;
      logic [DATA_BITS-1:0]    data;
   } cmd_type;

   // A command together with its valid flag.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_xfer_type;

endpackage

### rtl/core/tagged_slot_table_refcount_top.sv
// Top level of the tagged slot table with per-entry reader counts.
// The block keeps a table of 16 slots. A store transfer places its entry in the
// lowest free slot (status stored) or reports the table full; a read transfer
// finds the lowest busy slot whose item id and owner id both match, returns it
// with its count decremented and frees the slot when the count reaches zero
// (status read hit), or reports a read miss. A stored reader count of zero is
// kept as one. In the table unit each item first has all slots compared and the
// lowest picked, then has its slot updated and the result register loaded; the
// update waits while an earlier result is not yet taken, and the table unit takes
// no new item before it is done with the last. A request transfer passes the
// input register and the head of the two-entry command queue, where the table
// unit compares the slots, before the update loads the result register. The
// input register and the queue keep taking requests while a result waits to be
// taken. No clearing pass follows reset; the busy flags clear at once.
`include "assert_macros.svh"

module tagged_slot_table_refcount_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // item_id, owner_id, reader_count, payload
   input  logic [0:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_item_id, out_owner_id, out_remaining, out_payload
   output logic [1:0]  rsp_tuser    // status
);

   tstr_pkg::cmd_xfer_type q_push;
   tstr_pkg::cmd_xfer_type q_head;
   logic                   q_ready;
   logic                   q_pop;

   tstr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (q_push),
      .q_ready    (q_ready)
   );

   tstr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_ready (q_ready),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   tstr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The table unit only takes commands that the queue really holds.
   `ASSERT_IMPLIES(a_pop_has_entry, clock, reset, q_pop, q_head.valid)

   // An accepted request is held in the front stage on the next cycle.
   `ASSERT_NEXT(a_req_held, clock, reset, req_tvalid && req_tready, q_push.valid)

   // A command refused by a full queue stays put until the queue takes it.
   `ASSERT_NEXT(a_push_stall, clock, reset, q_push.valid && !q_ready, q_push.valid && $stable(q_push.cmd))

endmodule

### rtl/core/tstr_front.sv
// Front stage: takes request transfers, decodes them and hands them to the queue.
module tstr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,  // item_id, owner_id, reader_count, payload
   input  logic [0:0]            req_tuser,  // opcode
   output tstr_pkg::cmd_xfer_type q_push,
   input  logic                  q_ready
);

   logic              valid_ff;
   logic              valid_in;
   tstr_pkg::cmd_type cmd_ff;
   tstr_pkg::cmd_type cmd_in;
   logic              take;
   logic              hand_off;
   logic [tstr_pkg::COUNT_BITS-1:0] raw_count;

   // The holding register frees up as soon as the queue takes its command.
   assign req_tready = !valid_ff || q_ready;
   assign take       = req_tvalid && req_tready;
   assign hand_off   = valid_ff && q_ready;
   assign raw_count  = req_tdata[31:24];

   // Decode the fields; a reader count of zero is kept as one so the first read frees the slot.
   always_comb begin
      cmd_in          = cmd_ff;
      cmd_in.op       = tstr_pkg::op_type'(req_tuser[0]);
      cmd_in.item_id  = req_tdata[15:0];
      cmd_in.owner_id = req_tdata[23:16];
      cmd_in.count    = (raw_count == '0) ? tstr_pkg::COUNT_BITS'(1) : raw_count;
      cmd_in.data     = tstr_pkg::DATA_BITS'(req_tdata[63:32]);
      if (!take) begin
         cmd_in = cmd_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (hand_off) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign q_push.valid = valid_ff;
   assign q_push.cmd   = cmd_ff;

endmodule

### rtl/core/tstr_queue.sv
// Short command queue that decouples the front stage from the table unit.
module tstr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tstr_pkg::cmd_xfer_type q_push,
   output logic                  q_ready,
   output tstr_pkg::cmd_xfer_type q_head,
   input  logic                  q_pop
);

   tstr_pkg::cmd_type              entry_mem [tstr_pkg::QUEUE_DEPTH];
   logic [tstr_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [tstr_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [tstr_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [tstr_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [tstr_pkg::QCNT_W-1:0]    fill_ff;
   logic [tstr_pkg::QCNT_W-1:0]    fill_in;
   logic                           push;
   logic                           pop;

   assign q_ready = (fill_ff != tstr_pkg::QCNT_W'(tstr_pkg::QUEUE_DEPTH));
   assign push    = q_push.valid && q_ready;
   assign pop     = q_pop && (fill_ff != '0);

   // Pointer and fill bookkeeping; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tstr_pkg::QPTR_W'(tstr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + tstr_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tstr_pkg::QPTR_W'(tstr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + tstr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + tstr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - tstr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_mem[wr_ptr_ff] <= q_push.cmd;
      end
   end

   assign q_head.valid = (fill_ff != '0);
   assign q_head.cmd   = entry_mem[rd_ptr_ff];

endmodule

### rtl/core/tstr_back.sv
// Table unit: slot storage, lowest-slot search, update and the result register.
module tstr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tstr_pkg::cmd_xfer_type q_head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,  // out_item_id, out_owner_id, out_remaining, out_payload
   output logic [1:0]            rsp_tuser   // status
);

   typedef enum logic {
      S_LOOK,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Slot contents; only entries marked busy are ever looked at.
   logic [tstr_pkg::SLOTS-1:0]      busy_ff;
   logic [tstr_pkg::SLOTS-1:0]      busy_in;
   logic [tstr_pkg::ITEM_BITS-1:0]  item_mem  [tstr_pkg::SLOTS];
   logic [tstr_pkg::OWNER_BITS-1:0] owner_mem [tstr_pkg::SLOTS];
   logic [tstr_pkg::COUNT_BITS-1:0] count_mem [tstr_pkg::SLOTS];
   logic [tstr_pkg::DATA_BITS-1:0]  data_mem  [tstr_pkg::SLOTS];

   tstr_pkg::cmd_type               cmd_ff;
   tstr_pkg::cmd_type               cmd_in;
   logic [tstr_pkg::SLOT_IDX_W-1:0] idx_ff;
   logic [tstr_pkg::SLOT_IDX_W-1:0] idx_in;
   logic                            found_ff;
   logic                            found_in;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   tstr_pkg::status_type              rsp_status_ff;
   tstr_pkg::status_type              rsp_status_in;
   logic [tstr_pkg::ITEM_BITS-1:0]    rsp_item_ff;
   logic [tstr_pkg::ITEM_BITS-1:0]    rsp_item_in;
   logic [tstr_pkg::OWNER_BITS-1:0]   rsp_owner_ff;
   logic [tstr_pkg::OWNER_BITS-1:0]   rsp_owner_in;
   logic [tstr_pkg::COUNT_BITS-1:0]   rsp_left_ff;
   logic [tstr_pkg::COUNT_BITS-1:0]   rsp_left_in;
   logic [tstr_pkg::PAYLOAD_BITS-1:0] rsp_payload_ff;
   logic [tstr_pkg::PAYLOAD_BITS-1:0] rsp_payload_in;

   logic                              free_hit;
   logic [tstr_pkg::SLOT_IDX_W-1:0]   free_idx;
   logic                              match_hit;
   logic [tstr_pkg::SLOT_IDX_W-1:0]   match_idx;
   logic                              out_free;
   logic                              wr_entry;
   logic                              wr_count;
   logic [tstr_pkg::COUNT_BITS-1:0]   cur_count;
   logic [tstr_pkg::COUNT_BITS-1:0]   left;

   // Priority search over all slots for the lowest free one and the lowest match.
   always_comb begin
      free_hit  = 1'b0;
      free_idx  = '0;
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = tstr_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_hit = 1'b1;
            free_idx = tstr_pkg::SLOT_IDX_W'(i);
         end
         if (busy_ff[i] && item_mem[i] == q_head.cmd.item_id &&
             owner_mem[i] == q_head.cmd.owner_id) begin
            match_hit = 1'b1;
            match_idx = tstr_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   // Count after the read; a stored count is never zero, the guard keeps it from wrapping.
   assign cur_count = count_mem[idx_ff];
   assign left      = (cur_count == '0) ? '0 : cur_count - tstr_pkg::COUNT_BITS'(1);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer: S_LOOK searches; S_EXEC updates the slot and loads the result once the output is free.
   always_comb begin
      state_in       = state_ff;
      busy_in        = busy_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      q_pop          = 1'b0;
      wr_entry       = 1'b0;
      wr_count       = 1'b0;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_item_in    = rsp_item_ff;
      rsp_owner_in   = rsp_owner_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         S_LOOK: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head.cmd;
               found_in = (q_head.cmd.op == tstr_pkg::OP_STORE) ? free_hit : match_hit;
               idx_in   = (q_head.cmd.op == tstr_pkg::OP_STORE) ? free_idx : match_idx;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in       = S_LOOK;
               rsp_valid_in   = 1'b1;
               rsp_item_in    = '0;
               rsp_owner_in   = '0;
               rsp_left_in    = '0;
               rsp_payload_in = '0;
               if (cmd_ff.op == tstr_pkg::OP_STORE) begin
                  if (found_ff) begin
                     busy_in[idx_ff] = 1'b1;
                     wr_entry        = 1'b1;
                     rsp_status_in   = tstr_pkg::ST_STORED;
                  end else begin
                     rsp_status_in   = tstr_pkg::ST_FULL;
                  end
               end else begin
                  if (found_ff) begin
                     wr_count       = 1'b1;
                     if (left == '0) begin
                        busy_in[idx_ff] = 1'b0;
                     end
                     rsp_status_in  = tstr_pkg::ST_HIT;
                     rsp_item_in    = item_mem[idx_ff];
                     rsp_owner_in   = owner_mem[idx_ff];
                     rsp_left_in    = left;
                     rsp_payload_in = tstr_pkg::PAYLOAD_BITS'(data_mem[idx_ff]);
                  end else begin
                     rsp_status_in  = tstr_pkg::ST_MISS;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOOK;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_item_ff    <= rsp_item_in;
      rsp_owner_ff   <= rsp_owner_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Slot contents are written by a store, and only the count changes on a read.
   always_ff @(posedge clock) begin
      if (wr_entry) begin
         item_mem[idx_ff]  <= cmd_ff.item_id;
         owner_mem[idx_ff] <= cmd_ff.owner_id;
         count_mem[idx_ff] <= cmd_ff.count;
         data_mem[idx_ff]  <= cmd_ff.data;
      end else if (wr_count) begin
         count_mem[idx_ff] <= left;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_payload_ff, rsp_left_ff, rsp_owner_ff, rsp_item_ff};

endmodule
